### rtl/pp_pkg.sv
// Shared constants and types for the pinhole point projection pipeline.
// No dependencies.
`default_nettype none
package pp_pkg;
  localparam int FRAC_BITS_DEF = 16;   // Q16.16 default
  localparam int COORD_W       = 32;   // coordinate and coefficient width
  localparam int COEF_PAIR_W   = 64;   // two packed coefficients per register
  localparam int LIMIT_W       = 13;   // image width / height registers
  localparam int SUM_W         = 66;   // exact signed row sum
  localparam int MAG_W         = 65;   // magnitude of a row sum
  localparam int NUM_COEF_REGS = 6;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd7;

  localparam logic [LIMIT_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [LIMIT_W-1:0] HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic signed [SUM_W-1:0] s0;
    logic signed [SUM_W-1:0] s1;
    logic signed [SUM_W-1:0] s2;
  } rows_t;

  typedef struct packed {
    logic zero;    // third row is zero
    logic neg_u;
    logic neg_v;
    logic ovf_u;   // quotient does not fit the divider width
    logic ovf_v;
  } div_flags_t;
endpackage
`default_nettype wire

### rtl/pinhole_point_projection.sv
// Top level of the pinhole point projection pipeline.
// Depends on pp_pkg, pp_rows, pp_prep, pp_div_step, pp_post.
//
// Usage:
//  - s_* stream: one word per 3D point; s_tdata = {z, y, x}, signed Q.F each.
//  - m_* stream: one word per point, same order; m_tdata = {v, u} (saturated
//    signed Q.F), m_tuser = {depth_invalid, in_image}.
//  - cfg_*: register writes, index 0..5 the packed matrix rows (low word =
//    even column), 6 image width, 7 image height. cfg_ready is always high;
//    write only while no point is in flight.
// Stages: two multiply/sum stages, two divider set-up stages, one restoring
// subtract stage per quotient bit and the output register. QW, the quotient
// width, is max(32, 13 + FRAC_BITS): 32 at Q16.16.
// Throughput: one point per cycle unless stalled; both quotients share one stage chain.
// Stalls: every stage holds its word while the next is full; bubbles are
// squeezed out, so the pipe keeps filling while m_tready is low and
// s_tready drops only once all stages are occupied.
// Reset: flushes all valid bits, matrix to zero, width 640, height 480.
`default_nettype none
module pinhole_point_projection #(
  parameter int FRAC_BITS = pp_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  input  wire logic [95:0] s_tdata,   // point_x[31:0], point_y[63:32], point_z[95:64]
  output logic      m_tvalid,
  input  wire logic m_tready,
  output logic [63:0] m_tdata,        // pixel_u[31:0], pixel_v[63:32]
  output logic [1:0]  m_tuser,        // in_image[0], depth_invalid[1]
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [pp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pp_pkg::COEF_PAIR_W-1:0] cfg_data
);
  import pp_pkg::*;
  localparam int QW = (FRAC_BITS + LIMIT_W > 32) ? FRAC_BITS + LIMIT_W : 32;

  // configuration
  logic [NUM_COEF_REGS-1:0][COEF_PAIR_W-1:0] coef;
  logic [LIMIT_W-1:0] image_width, image_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef         <= '0;
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW0_C01: coef[0] <= cfg_data;
        REG_ROW0_C23: coef[1] <= cfg_data;
        REG_ROW1_C01: coef[2] <= cfg_data;
        REG_ROW1_C23: coef[3] <= cfg_data;
        REG_ROW2_C01: coef[4] <= cfg_data;
        REG_ROW2_C23: coef[5] <= cfg_data;
        REG_WIDTH:    image_width  <= cfg_data[LIMIT_W-1:0];
        REG_HEIGHT:   image_height <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // matrix product
  rows_t rows;
  logic  rows_valid, rows_ready;

  pp_rows #(.FRAC_BITS(FRAC_BITS)) u_rows (
    .clk, .rst,
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .x         ($signed(s_tdata[31:0])),
    .y         ($signed(s_tdata[63:32])),
    .z         ($signed(s_tdata[95:64])),
    .coef      (coef),
    .out_valid (rows_valid),
    .out_ready (rows_ready),
    .rows      (rows)
  );

  // divider chain: index 0 is the set-up output, index QW the final quotient
  logic [QW:0]        st_valid, st_ready;
  logic [MAG_W-1:0]   st_rem_u [QW+1];
  logic [MAG_W-1:0]   st_rem_v [QW+1];
  logic [QW-1:0]      st_q_u   [QW+1];
  logic [QW-1:0]      st_q_v   [QW+1];
  logic [MAG_W-1:0]   st_den   [QW+1];
  div_flags_t         st_flags [QW+1];

  pp_prep #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_prep (
    .clk, .rst,
    .in_valid  (rows_valid),
    .in_ready  (rows_ready),
    .rows      (rows),
    .out_valid (st_valid[0]),
    .out_ready (st_ready[0]),
    .rem_u     (st_rem_u[0]),
    .rem_v     (st_rem_v[0]),
    .q_u       (st_q_u[0]),
    .q_v       (st_q_v[0]),
    .den       (st_den[0]),
    .flags     (st_flags[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_div
    pp_div_step #(.QW(QW)) u_step (
      .clk, .rst,
      .in_valid  (st_valid[k]),
      .in_ready  (st_ready[k]),
      .in_rem_u  (st_rem_u[k]),
      .in_rem_v  (st_rem_v[k]),
      .in_q_u    (st_q_u[k]),
      .in_q_v    (st_q_v[k]),
      .in_den    (st_den[k]),
      .in_flags  (st_flags[k]),
      .out_valid (st_valid[k+1]),
      .out_ready (st_ready[k+1]),
      .rem_u     (st_rem_u[k+1]),
      .rem_v     (st_rem_v[k+1]),
      .q_u       (st_q_u[k+1]),
      .q_v       (st_q_v[k+1]),
      .den       (st_den[k+1]),
      .flags     (st_flags[k+1])
    );
  end

  // final remainders and divisor are not needed past the last step
  logic [MAG_W-1:0] unused_tail;
  assign unused_tail = st_rem_u[QW] ^ st_rem_v[QW] ^ st_den[QW];

  logic [COORD_W-1:0] pixel_u, pixel_v;
  logic in_image, depth_invalid;

  pp_post #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_post (
    .clk, .rst,
    .in_valid      (st_valid[QW]),
    .in_ready      (st_ready[QW]),
    .q_u           (st_q_u[QW]),
    .q_v           (st_q_v[QW]),
    .flags         (st_flags[QW]),
    .width         (image_width),
    .height        (image_height),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .pixel_u       (pixel_u),
    .pixel_v       (pixel_v),
    .in_image      (in_image),
    .depth_invalid (depth_invalid)
  );

  assign m_tdata = {pixel_v, pixel_u};
  assign m_tuser = {depth_invalid, in_image};

`ifndef NO_ASSERTIONS
  a_zero_depth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && depth_invalid |-> pixel_u == '0 && pixel_v == '0 && !in_image)
    else $error("zero depth result not cleared");
  a_inside_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && in_image |-> !pixel_u[COORD_W-1] && pixel_u != '0
                          && !pixel_v[COORD_W-1] && pixel_v != '0)
    else $error("in_image with non-positive coordinate");
  a_reset_flush: assert property (@(posedge clk) rst |=> !m_tvalid && !st_valid[0])
    else $error("valid bit survived reset");
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    !st_valid[QW] |-> st_ready[QW-1])
    else $error("empty stage blocks its predecessor");
`endif
endmodule
`default_nettype wire

### rtl/pp_rows.sv
// Two-stage matrix product: nine registered products, then exact row sums.
// Depends on pp_pkg.
`default_nettype none
module pp_rows #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic signed [pp_pkg::COORD_W-1:0] x,
  input  wire logic signed [pp_pkg::COORD_W-1:0] y,
  input  wire logic signed [pp_pkg::COORD_W-1:0] z,
  input  wire logic [pp_pkg::NUM_COEF_REGS-1:0][pp_pkg::COEF_PAIR_W-1:0] coef,
  output logic      out_valid,
  input  wire logic out_ready,
  output pp_pkg::rows_t rows
);
  import pp_pkg::*;

  logic signed [2*COORD_W-1:0] prod [3][3];
  logic signed [2*COORD_W-1:0] prod_next [3][3];
  logic signed [SUM_W-1:0] sum_next [3];
  logic pv, rdy_p, rdy_s;

  assign rdy_s    = !out_valid || out_ready;
  assign rdy_p    = !pv || rdy_s;
  assign in_ready = rdy_p;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_next[r][0] = $signed(coef[2*r][COORD_W-1:0]) * x;
      prod_next[r][1] = $signed(coef[2*r][2*COORD_W-1:COORD_W]) * y;
      prod_next[r][2] = $signed(coef[2*r+1][COORD_W-1:0]) * z;
      // constant column scaled by 1.0
      sum_next[r] = SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2])
                  + (SUM_W'($signed(coef[2*r+1][2*COORD_W-1:COORD_W])) <<< FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_p) pv <= in_valid;
      if (rdy_s) out_valid <= pv;
    end
    if (rdy_p && in_valid) prod <= prod_next;
    if (rdy_s && pv) begin
      rows.s0 <= sum_next[0];
      rows.s1 <= sum_next[1];
      rows.s2 <= sum_next[2];
    end
  end
endmodule
`default_nettype wire

### rtl/pp_prep.sv
// Divider set-up: magnitudes and signs, then overflow test and start remainder.
// Depends on pp_pkg.
`default_nettype none
module pp_prep #(
  parameter int FRAC_BITS = 16,
  parameter int QW        = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire pp_pkg::rows_t rows,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [pp_pkg::MAG_W-1:0] rem_u,
  output logic [pp_pkg::MAG_W-1:0] rem_v,
  output logic [QW-1:0]            q_u,
  output logic [QW-1:0]            q_v,
  output logic [pp_pkg::MAG_W-1:0] den,
  output pp_pkg::div_flags_t       flags
);
  import pp_pkg::*;
  localparam int NW = MAG_W + FRAC_BITS;

  logic av, rdy_a, rdy_b;
  logic [MAG_W-1:0] mag0, mag1, mag2;
  logic neg0, neg1, neg2, zero2;
  logic [SUM_W-1:0] a0, a1, a2;
  logic [NW-1:0] num_u, num_v;
  logic ovf_u_next, ovf_v_next;

  assign rdy_b    = !out_valid || out_ready;
  assign rdy_a    = !av || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    a0 = rows.s0[SUM_W-1] ? (~rows.s0 + 1'b1) : rows.s0;
    a1 = rows.s1[SUM_W-1] ? (~rows.s1 + 1'b1) : rows.s1;
    a2 = rows.s2[SUM_W-1] ? (~rows.s2 + 1'b1) : rows.s2;
    num_u = NW'(mag0) << FRAC_BITS;
    num_v = NW'(mag1) << FRAC_BITS;
    ovf_u_next = MAG_W'(num_u >> QW) >= mag2;
    ovf_v_next = MAG_W'(num_v >> QW) >= mag2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      av        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) av <= in_valid;
      if (rdy_b) out_valid <= av;
    end
    if (rdy_a && in_valid) begin
      mag0  <= a0[MAG_W-1:0];
      mag1  <= a1[MAG_W-1:0];
      mag2  <= a2[MAG_W-1:0];
      neg0  <= rows.s0[SUM_W-1];
      neg1  <= rows.s1[SUM_W-1];
      neg2  <= rows.s2[SUM_W-1];
      zero2 <= (rows.s2 == '0);
    end
    if (rdy_b && av) begin
      rem_u       <= MAG_W'(num_u >> QW);
      rem_v       <= MAG_W'(num_v >> QW);
      q_u         <= num_u[QW-1:0];
      q_v         <= num_v[QW-1:0];
      den         <= mag2;
      flags.zero  <= zero2;
      flags.neg_u <= neg0 ^ neg2;
      flags.neg_v <= neg1 ^ neg2;
      flags.ovf_u <= ovf_u_next;
      flags.ovf_v <= ovf_v_next;
    end
  end
endmodule
`default_nettype wire

### rtl/pp_div_step.sv
// One restoring-division stage, one quotient bit for each of the u and v lanes.
// Depends on pp_pkg.
`default_nettype none
module pp_div_step #(
  parameter int QW = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic [pp_pkg::MAG_W-1:0] in_rem_u,
  input  wire logic [pp_pkg::MAG_W-1:0] in_rem_v,
  input  wire logic [QW-1:0]            in_q_u,
  input  wire logic [QW-1:0]            in_q_v,
  input  wire logic [pp_pkg::MAG_W-1:0] in_den,
  input  wire pp_pkg::div_flags_t       in_flags,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [pp_pkg::MAG_W-1:0] rem_u,
  output logic [pp_pkg::MAG_W-1:0] rem_v,
  output logic [QW-1:0]            q_u,
  output logic [QW-1:0]            q_v,
  output logic [pp_pkg::MAG_W-1:0] den,
  output pp_pkg::div_flags_t       flags
);
  import pp_pkg::*;

  logic [MAG_W:0] tu, tv, du, dv;
  logic ge_u, ge_v;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    // remainder shifted left, next dividend bit in from the quotient word
    tu   = {in_rem_u, in_q_u[QW-1]};
    tv   = {in_rem_v, in_q_v[QW-1]};
    du   = tu - {1'b0, in_den};
    dv   = tv - {1'b0, in_den};
    ge_u = tu >= {1'b0, in_den};
    ge_v = tv >= {1'b0, in_den};
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
    if (in_ready && in_valid) begin
      rem_u <= ge_u ? du[MAG_W-1:0] : tu[MAG_W-1:0];
      rem_v <= ge_v ? dv[MAG_W-1:0] : tv[MAG_W-1:0];
      q_u   <= {in_q_u[QW-2:0], ge_u};
      q_v   <= {in_q_v[QW-2:0], ge_v};
      den   <= in_den;
      flags <= in_flags;
    end
  end
endmodule
`default_nettype wire

### rtl/pp_post.sv
// Output stage: zero-depth clear, sign, saturation, bounds test; holds the result word.
// Depends on pp_pkg.
`default_nettype none
module pp_post #(
  parameter int FRAC_BITS = 16,
  parameter int QW        = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic [QW-1:0] q_u,
  input  wire logic [QW-1:0] q_v,
  input  wire pp_pkg::div_flags_t flags,
  input  wire logic [pp_pkg::LIMIT_W-1:0] width,
  input  wire logic [pp_pkg::LIMIT_W-1:0] height,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [pp_pkg::COORD_W-1:0] pixel_u,
  output logic [pp_pkg::COORD_W-1:0] pixel_v,
  output logic      in_image,
  output logic      depth_invalid
);
  import pp_pkg::*;
  localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic [COORD_W-1:0] u_next, v_next;
  logic in_u, in_v;

  function automatic logic [COORD_W-1:0] sat(input logic [QW-1:0] q, input logic neg,
                                             input logic ovf);
    logic [COORD_W-1:0] r;
    if (!neg) r = (ovf || q > QW'(POS_MAX)) ? POS_MAX : q[COORD_W-1:0];
    else      r = (ovf || q > QW'(NEG_MIN)) ? NEG_MIN : (~q[COORD_W-1:0] + 1'b1);
    return r;
  endfunction

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    u_next = flags.zero ? '0 : sat(q_u, flags.neg_u, flags.ovf_u);
    v_next = flags.zero ? '0 : sat(q_v, flags.neg_v, flags.ovf_v);
    in_u = !flags.neg_u && !flags.ovf_u && (q_u != '0) && (q_u < (QW'(width) << FRAC_BITS));
    in_v = !flags.neg_v && !flags.ovf_v && (q_v != '0) && (q_v < (QW'(height) << FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
    if (in_ready && in_valid) begin
      pixel_u       <= u_next;
      pixel_v       <= v_next;
      in_image      <= !flags.zero && in_u && in_v;
      depth_invalid <= flags.zero;
    end
  end
endmodule
`default_nettype wire
